FILE: hw/rtl/kelc_pkg.sv
`default_nettype none

package kelc_pkg;

	// Length of the entry command that the matcher recognizes.
	localparam int unsigned CMD_LEN = 11;

	// Reset value of the auto-lock timeout, in ticks.
	localparam logic [23:0] TIMEOUT_RESET = 24'd6000000;

	// Authenticator verdict codes.
	localparam logic [1:0] VERDICT_RUNNING = 2'd0;
	localparam logic [1:0] VERDICT_PASS    = 2'd1;
	localparam logic [1:0] VERDICT_FAIL    = 2'd2;

	// Link authentication commands.
	localparam logic [1:0] AUTH_NONE  = 2'd0;
	localparam logic [1:0] AUTH_SET   = 2'd1;
	localparam logic [1:0] AUTH_CLEAR = 2'd2;

	// One-shot frame requests.
	localparam logic [1:0] FRAME_NONE = 2'd0;
	localparam logic [1:0] FRAME_AUTH = 2'd1;
	localparam logic [1:0] FRAME_LOCK = 2'd2;

	// One input transaction: a scheduler tick with an optional radio byte.
	typedef struct packed {
		logic       byte_valid;
		logic [7:0] rx_byte;
		logic [1:0] auth_verdict;
		logic       link_connected;
		logic       link_authenticated;
	} in_item_t;

	// One result transaction.
	typedef struct packed {
		logic [1:0] auth_command;
		logic [1:0] oneshot_frame;
		logic       periodic_enable;
		logic [1:0] access_mode;
	} out_item_t;

	// Matcher verdict for one byte.
	typedef struct packed {
		logic [3:0] next_pos;
		logic       hit;
	} match_t;

	// Expected byte at each command position; positions past the command expect zero.
	function automatic logic [7:0] cmd_byte(input logic [3:0] idx);
		logic [7:0] b;
		case (idx)
			4'd0:    b = 8'h55;
			4'd1:    b = 8'h53;
			4'd2:    b = 8'h45;
			4'd3:    b = 8'h52;
			4'd4:    b = 8'h5F;
			4'd5:    b = 8'h49;
			4'd6:    b = 8'h4E;
			4'd7:    b = 8'h5F;
			4'd8:    b = 8'h43;
			4'd9:    b = 8'h41;
			4'd10:   b = 8'h52;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/kelc_matcher.sv
`default_nettype none

module kelc_matcher
	import kelc_pkg::*;
(
	input  wire logic [3:0] pos,
	input  wire logic [7:0] rx_byte,
	output match_t          result
);

	logic [3:0] pos_inc;

	assign pos_inc = pos + 4'd1;

	// Advance on the expected byte (flagging a hit and returning to the start on the
	// last one), restart at one on the first command byte, otherwise fall back to the start.
	always_comb begin
		result.hit      = 1'b0;
		result.next_pos = 4'd0;
		if (rx_byte == cmd_byte(pos)) begin
			if (pos_inc >= 4'(CMD_LEN)) begin
				result.hit = 1'b1;
			end else begin
				result.next_pos = pos_inc;
			end
		end else if (rx_byte == cmd_byte(4'd0)) begin
			result.next_pos = 4'd1;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/kelc_fsm.sv
`default_nettype none

module kelc_fsm
	import kelc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        advance,
	input  in_item_t         item,
	input  wire logic [23:0] timeout,
	output out_item_t        result
);

	typedef enum logic [1:0] {
		MODE_LOCKED   = 2'd0,
		MODE_WAIT     = 2'd1,
		MODE_COMPLETE = 2'd2
	} mode_t;

	mode_t      mode_q, mode_d, mode_mid;
	logic [3:0] pos_q, pos_d;
	logic [23:0] count_q, count_d;
	out_item_t  result_q, result_d;
	match_t     match;

	kelc_matcher u_matcher (
		.pos     (pos_q),
		.rx_byte (item.rx_byte),
		.result  (match)
	);

	// Byte handling first, then the per-tick mode update.
	always_comb begin
		mode_mid = mode_q;
		mode_d   = mode_q;
		pos_d    = pos_q;
		count_d  = count_q;
		result_d.auth_command    = AUTH_NONE;
		result_d.oneshot_frame   = FRAME_NONE;
		result_d.periodic_enable = 1'b0;

		if (item.byte_valid) begin
			case (mode_q)
				MODE_WAIT: begin
					pos_d = match.next_pos;
					if (match.hit) begin
						result_d.auth_command  = AUTH_CLEAR;
						result_d.oneshot_frame = FRAME_LOCK;
						mode_mid = MODE_COMPLETE;
						pos_d    = 4'd0;
						count_d  = 24'd0;
					end
				end
				MODE_LOCKED: begin
					if (item.auth_verdict == VERDICT_PASS) begin
						result_d.auth_command  = AUTH_SET;
						result_d.oneshot_frame = FRAME_AUTH;
						mode_mid = MODE_WAIT;
						pos_d    = 4'd0;
						count_d  = 24'd0;
					end else if (item.auth_verdict == VERDICT_FAIL) begin
						result_d.auth_command = AUTH_CLEAR;
						pos_d    = 4'd0;
						count_d  = 24'd0;
					end
				end
				default: begin
				end
			endcase
		end

		mode_d = mode_mid;
		case (mode_mid)
			MODE_LOCKED: begin
				result_d.periodic_enable = item.link_connected & ~item.link_authenticated;
			end
			MODE_WAIT: begin
				if (count_d < timeout) begin
					count_d = count_d + 24'd1;
				end else begin
					result_d.auth_command  = AUTH_CLEAR;
					result_d.oneshot_frame = FRAME_LOCK;
					mode_d  = MODE_COMPLETE;
					pos_d   = 4'd0;
					count_d = 24'd0;
				end
			end
			default: begin
				if (!item.link_connected) begin
					mode_d = MODE_LOCKED;
				end
			end
		endcase
		result_d.access_mode = mode_d;
	end

	// State and the result register move together when a tick is processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_LOCKED;
			pos_q    <= 4'd0;
			count_q  <= 24'd0;
			result_q <= '0;
		end else if (advance) begin
			mode_q   <= mode_d;
			pos_q    <= pos_d;
			count_q  <= count_d;
			result_q <= result_d;
		end
	end

	assign result = result_q;

endmodule

`default_nettype wire

FILE: hw/rtl/keyless_entry_lock_controller.sv
`default_nettype none

// Keyless entry lock controller. Each input transaction is one scheduler tick
// and yields exactly one result transaction. A tick is captured in an input
// register, the mode update runs combinationally against the mode, command match
// position and auto-lock count, and the result lands in an output register, so
// one tick is taken every cycle unless the result stalls; the state update loop,
// closed in one pass, sets that rate. A stalled result holds the pipeline while
// the input register stays full. The auto_lock_timeout register is written
// through the cfg channel, which is always ready, and resets to 6000000 ticks.

module keyless_entry_lock_controller
	import kelc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output out_item_t        out_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [23:0] cfg_data
);

	logic        valid_s1;
	in_item_t    item_s1;
	logic        out_valid_q;
	logic        advance;
	logic        in_accept;
	logic [23:0] timeout_q;

	// The captured tick moves on when the result register is free or draining.
	assign advance   = valid_s1 & (~out_valid_q | ~out_stall);
	assign in_stall  = valid_s1 & ~advance;
	assign in_accept = in_valid & ~in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;

	// Handshake state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (~out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1 <= in_data;
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			timeout_q <= cfg_data;
		end
	end

	kelc_fsm u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.timeout (timeout_q),
		.result  (out_data)
	);

endmodule

`default_nettype wire
